// File: design/voxel_ray_cast_occupancy_macros.svh
// ----------------------------------------------------------------------------
// Voxel ray cast occupancy assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef VOXEL_RAY_CAST_OCCUPANCY_MACROS_SVH
`define VOXEL_RAY_CAST_OCCUPANCY_MACROS_SVH
`ifndef SYNTHESIS
`define VRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel ray cast assertion failed");
`define VRC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel ray cast assertion failed");
`else
`define VRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define VRC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/vrco_pkg.sv
// ----------------------------------------------------------------------------
// Voxel ray cast occupancy package
// Command, status and register codes, sequencer states and fixed widths.
// ----------------------------------------------------------------------------
package vrco_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_CNT_W  = 16;
  localparam logic [7:0] FULL_COST = 8'd255;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_RANGE   = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_RES   = 3'd0,
    REG_RANGE_SQ  = 3'd1,
    REG_FREE_LIM  = 3'd2,
    REG_OCC_LIM   = 3'd3,
    REG_OCC_ONLY  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_OCC_RD,
    S_OCC_WR,
    S_WALK_SETUP,
    S_WALK_RD,
    S_WALK_WR,
    S_RD_RD,
    S_RD_EVAL,
    S_DIV,
    S_RESP
  } state_t;

endpackage

// File: design/vrco_grid_mem.sv
// ----------------------------------------------------------------------------
// Voxel grid counter memory
// One write port and one registered read port holding both counters per voxel.
// ----------------------------------------------------------------------------
module vrco_grid_mem #(
  parameter int DEPTH  = 131072,
  parameter int ADDR_W = 17,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/vrco_cost_div.sv
// ----------------------------------------------------------------------------
// Cost divider
// Restoring divider that yields an 8-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module vrco_cost_div #(
  parameter int CNT_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W+7:0] numer,
  input  logic [CNT_W-1:0] denom,
  output logic             done,
  output logic [7:0]       quot
);

  logic [CNT_W-1:0] rem;
  logic [7:0]       low;
  logic [CNT_W-1:0] den;
  logic [2:0]       cnt;
  logic             busy;
  logic [CNT_W:0]   shifted;
  logic             fits;

  // The numerator is below denom * 256, so its top part already sits below denom.
  assign shifted = {rem, low[7]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer[CNT_W+7:8];
      low  <= numer[7:0];
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? CNT_W'(shifted - {1'b0, den}) : shifted[CNT_W-1:0];
      low  <= {low[6:0], 1'b0};
      quot <= {quot[6:0], fits};
    end
  end

endmodule

// File: design/voxel_ray_cast_occupancy.sv
// ----------------------------------------------------------------------------
// Voxel ray cast occupancy grid
// Occupancy and visit counters per voxel with 3D line traversal and cost reads.
// ----------------------------------------------------------------------------
// Usage: one command enters on the in channel (in_valid/in_ready) and exactly
// one result leaves on the out channel (out_valid/out_ready) per transaction.
// A clear command sweeps the counter memory one voxel per cycle, over all
// GRID_X*GRID_Y*GRID_Z voxels (131072 with the default grid).
// The same sweep runs right after reset; in_ready stays low until it ends.
// An insert runs through the shared 17x17 multiplier (three squares for the
// range test, three scalings into voxel space), the range and grid checks,
// a read and a write of the occupied counter, the line setup, a read and a
// write per voxel on the line from the camera voxel (a read-modify-write on
// the single memory address) and the hand-off; a failed check goes straight
// to the hand-off and occupied_only skips the walk. A read takes a memory
// read, the cost check, the divider when the cost needs it, and the hand-off.
// The block works on one transaction at a time; in_ready is high only while
// the sequencer is idle. The result sits in an output register, so a new
// transaction is taken while an earlier result still waits, and a stalled
// receiver holds only the sequencer at its final hand-off step.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered and are
// expected only while the block is idle.
// ----------------------------------------------------------------------------
`include "voxel_ray_cast_occupancy_macros.svh"

module voxel_ray_cast_occupancy #(
  parameter int GRID_X     = 64,
  parameter int GRID_Y     = 64,
  parameter int GRID_Z     = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        cmd,
  input  logic signed [15:0]                pos_x,
  input  logic signed [15:0]                pos_y,
  input  logic signed [15:0]                pos_z,
  input  logic [5:0]                        voxel_x,
  input  logic [5:0]                        voxel_y,
  input  logic [4:0]                        voxel_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic [7:0]                        cost,
  output logic [vrco_pkg::OUT_CNT_W-1:0]    occupied_count,
  output logic [vrco_pkg::OUT_CNT_W-1:0]    visit_count,
  input  logic                              cfg_we,
  input  logic [vrco_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vrco_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int GMAX  = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z)
                                           : ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
  localparam int CW    = (GMAX > 2) ? $clog2(GMAX) : 1;
  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int CB    = COUNT_BITS;
  localparam int EW    = CW + 3;
  localparam logic [CW-1:0] CAM_X = CW'(GRID_X / 2);
  localparam logic [CW-1:0] CAM_Y = CW'(GRID_Y / 2);
  localparam logic [CW-1:0] CAM_Z = '0;

  // Configuration registers.
  logic [15:0] inv_resolution;
  logic [31:0] max_range_sq;
  logic [15:0] free_limit;
  logic [15:0] occupied_limit;
  logic        occupied_only;

  vrco_pkg::state_t state, state_next;

  // Transaction registers.
  logic signed [15:0] pos [3];
  logic [CW-1:0]      tgt [3];
  logic [2:0]         tgt_bad;
  logic [31:0]        sq_acc;
  logic [2:0]         mul_cnt;
  logic signed [33:0] prod_r;
  logic [AW-1:0]      clr_addr;
  logic               clr_cmd;
  logic [CB-1:0]      max_visits;

  // Line walk state, one lane per axis.
  logic [CW-1:0]        pcur [3];
  logic [CW-1:0]        dlt [3];
  logic                 inc_neg [3];
  logic signed [EW-1:0] err [3];
  logic [1:0]           major;
  logic [CW-1:0]        wlen;
  logic [CW-1:0]        step;

  // Result held until the output register is free.
  logic [1:0]    res_status;
  logic [7:0]    res_cost;
  logic [CB-1:0] res_occ;
  logic [CB-1:0] res_vis;

  // Memory and divider hookup.
  logic [AW-1:0]   mem_addr;
  logic [2*CB-1:0] mem_rdata;
  logic            mem_we;
  logic [2*CB-1:0] mem_wdata;
  logic [CB-1:0]   rd_occ, rd_vis, occ_inc, vis_inc;
  logic            div_start, div_done;
  logic [7:0]      div_quot;
  logic [CB+7:0]   div_numer;
  logic [CB-1:0]   vis_gap;
  logic            accept, out_free;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    logic [63:0] t;
    t = (64'(x) * 64'(GRID_Y) + 64'(y)) * 64'(GRID_Z) + 64'(z);
    return t[AW-1:0];
  endfunction

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == {CB{1'b1}}) ? v : CB'(v + 1'b1);
  endfunction

  function automatic logic [CW-1:0] cam_of(input logic [1:0] a);
    logic [CW-1:0] c;
    case (a)
      2'd0:    c = CAM_X;
      2'd1:    c = CAM_Y;
      default: c = CAM_Z;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] grid_of(input logic [1:0] a);
    logic [31:0] g;
    case (a)
      2'd0:    g = 32'(GRID_X);
      2'd1:    g = 32'(GRID_Y);
      default: g = 32'(GRID_Z);
    endcase
    return g;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == vrco_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_resolution <= 16'd2560;
      max_range_sq   <= 32'd3221225472;
      free_limit     <= 16'd0;
      occupied_limit <= 16'd65535;
      occupied_only  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vrco_pkg::REG_INV_RES:  inv_resolution <= cfg_data[15:0];
        vrco_pkg::REG_RANGE_SQ: max_range_sq   <= cfg_data;
        vrco_pkg::REG_FREE_LIM: free_limit     <= cfg_data[15:0];
        vrco_pkg::REG_OCC_LIM:  occupied_limit <= cfg_data[15:0];
        vrco_pkg::REG_OCC_ONLY: occupied_only  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operands: three squares, then three scalings.
  logic [1:0]         mul_axis;
  logic signed [16:0] mul_a, mul_b;
  always_comb begin
    mul_axis = (mul_cnt >= 3'd3) ? 2'(mul_cnt - 3'd3) : mul_cnt[1:0];
    if (mul_axis == 2'd3) begin
      mul_axis = 2'd2;
    end
    mul_a = 17'(pos[mul_axis]);
    mul_b = (mul_cnt < 3'd3) ? 17'(pos[mul_axis]) : $signed({1'b0, inv_resolution});
  end

  // Voxel index of the scaled product, truncated toward zero after the offset.
  logic [1:0]         res_axis;
  logic signed [34:0] tix;
  logic [34:0]        tmag;
  logic [18:0]        tq;
  logic               tok;
  always_comb begin
    res_axis = (mul_cnt >= 3'd4) ? 2'(mul_cnt - 3'd4) : 2'd0;
    tix      = 35'(prod_r) + $signed({19'(cam_of(res_axis)), 16'b0});
    tmag     = tix[34] ? 35'(-tix) : 35'(tix);
    tq       = tmag[34:16];
    tok      = tix[34] ? (tq == '0) : (32'(tq) < grid_of(res_axis));
  end

  // Line setup from the target, evaluated in the setup cycle.
  logic [CW:0]   sdiff [3];
  logic [CW-1:0] sd [3];
  logic          sneg [3];
  logic [1:0]    smaj;
  logic [CW-1:0] slen;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sdiff[a] = {1'b0, tgt[a]} - {1'b0, cam_of(2'(a))};
      sneg[a]  = sdiff[a][CW];
      sd[a]    = sneg[a] ? CW'(-sdiff[a]) : sdiff[a][CW-1:0];
    end
    if (sd[0] >= sd[1] && sd[0] >= sd[2]) begin
      smaj = 2'd0;
    end else if (sd[1] >= sd[0] && sd[1] >= sd[2]) begin
      smaj = 2'd1;
    end else begin
      smaj = 2'd2;
    end
    slen = sd[smaj];
  end

  assign rd_occ  = mem_rdata[2*CB-1:CB];
  assign rd_vis  = mem_rdata[CB-1:0];
  assign occ_inc = sat_inc(rd_occ);
  assign vis_inc = sat_inc(rd_vis);
  assign vis_gap = max_visits - rd_vis;
  assign div_numer = {vis_gap, 8'b0} - (CB+8)'(vis_gap);

  // Sequencer next state and memory control.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wdata  = '0;
    mem_addr   = (state == vrco_pkg::S_WALK_RD || state == vrco_pkg::S_WALK_WR)
               ? cell_addr(pcur[0], pcur[1], pcur[2])
               : cell_addr(tgt[0], tgt[1], tgt[2]);
    div_start  = 1'b0;
    unique case (state)
      vrco_pkg::S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
        if (clr_addr == AW'(CELLS - 1)) begin
          state_next = clr_cmd ? vrco_pkg::S_RESP : vrco_pkg::S_IDLE;
        end
      end
      vrco_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            vrco_pkg::CMD_CLEAR:  state_next = vrco_pkg::S_CLR;
            vrco_pkg::CMD_INSERT: state_next = vrco_pkg::S_MUL;
            vrco_pkg::CMD_READ: begin
              if (32'(voxel_x) < 32'(GRID_X) && 32'(voxel_y) < 32'(GRID_Y) &&
                  32'(voxel_z) < 32'(GRID_Z)) begin
                state_next = vrco_pkg::S_RD_RD;
              end else begin
                state_next = vrco_pkg::S_RESP;
              end
            end
            default: state_next = vrco_pkg::S_RESP;
          endcase
        end
      end
      vrco_pkg::S_MUL: begin
        if (mul_cnt == 3'd6) begin
          state_next = vrco_pkg::S_EVAL;
        end
      end
      vrco_pkg::S_EVAL: begin
        state_next = (sq_acc > max_range_sq || tgt_bad != '0) ? vrco_pkg::S_RESP
                                                                 : vrco_pkg::S_OCC_RD;
      end
      vrco_pkg::S_OCC_RD: state_next = vrco_pkg::S_OCC_WR;
      vrco_pkg::S_OCC_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = {occ_inc, rd_vis};
        state_next = occupied_only ? vrco_pkg::S_RESP : vrco_pkg::S_WALK_SETUP;
      end
      vrco_pkg::S_WALK_SETUP: state_next = vrco_pkg::S_WALK_RD;
      vrco_pkg::S_WALK_RD:    state_next = vrco_pkg::S_WALK_WR;
      vrco_pkg::S_WALK_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = {rd_occ, vis_inc};
        state_next = (step == wlen) ? vrco_pkg::S_RESP : vrco_pkg::S_WALK_RD;
      end
      vrco_pkg::S_RD_RD: state_next = vrco_pkg::S_RD_EVAL;
      vrco_pkg::S_RD_EVAL: begin
        if (rd_occ == '0 && !(32'(rd_vis) <= 32'(free_limit)) &&
            !(32'(rd_vis) > 32'(occupied_limit)) && rd_vis < max_visits) begin
          div_start  = 1'b1;
          state_next = vrco_pkg::S_DIV;
        end else begin
          state_next = vrco_pkg::S_RESP;
        end
      end
      vrco_pkg::S_DIV: begin
        if (div_done) begin
          state_next = vrco_pkg::S_RESP;
        end
      end
      vrco_pkg::S_RESP: begin
        if (out_free) begin
          state_next = vrco_pkg::S_IDLE;
        end
      end
      default: state_next = vrco_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrco_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      clr_cmd    <= 1'b0;
      max_visits <= '0;
      mul_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A new result may replace the one leaving in the same cycle.
      if (state == vrco_pkg::S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        vrco_pkg::S_CLR: begin
          clr_addr   <= AW'(clr_addr + 1'b1);
          max_visits <= '0;
        end
        vrco_pkg::S_IDLE: begin
          clr_addr <= '0;
          mul_cnt  <= '0;
          if (accept) begin
            clr_cmd <= 1'b1;
          end
        end
        vrco_pkg::S_MUL: mul_cnt <= mul_cnt + 3'd1;
        vrco_pkg::S_WALK_WR: begin
          if (vis_inc > max_visits) begin
            max_visits <= vis_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      vrco_pkg::S_IDLE: begin
        if (accept) begin
          pos[0]     <= pos_x;
          pos[1]     <= pos_y;
          pos[2]     <= pos_z;
          tgt[0]     <= CW'(voxel_x);
          tgt[1]     <= CW'(voxel_y);
          tgt[2]     <= CW'(voxel_z);
          tgt_bad    <= '0;
          sq_acc     <= '0;
          res_status <= (cmd == vrco_pkg::CMD_READ &&
                         !(32'(voxel_x) < 32'(GRID_X) && 32'(voxel_y) < 32'(GRID_Y) &&
                           32'(voxel_z) < 32'(GRID_Z))) ? vrco_pkg::ST_OUTSIDE
                                                        : vrco_pkg::ST_DONE;
          res_cost   <= '0;
          res_occ    <= '0;
          res_vis    <= '0;
        end
      end
      vrco_pkg::S_MUL: begin
        prod_r <= mul_a * mul_b;
        if (mul_cnt >= 3'd1 && mul_cnt <= 3'd3) begin
          sq_acc <= sq_acc + prod_r[31:0];
        end
        if (mul_cnt >= 3'd4) begin
          tgt[res_axis]     <= tix[34] ? '0 : CW'(tq);
          tgt_bad[res_axis] <= !tok;
        end
      end
      vrco_pkg::S_EVAL: begin
        if (sq_acc > max_range_sq) begin
          res_status <= vrco_pkg::ST_RANGE;
        end else if (tgt_bad != '0) begin
          res_status <= vrco_pkg::ST_OUTSIDE;
        end
      end
      vrco_pkg::S_WALK_SETUP: begin
        for (int a = 0; a < 3; a++) begin
          pcur[a]    <= cam_of(2'(a));
          dlt[a]     <= sd[a];
          inc_neg[a] <= sneg[a];
          err[a]     <= $signed({2'b00, sd[a], 1'b0}) - $signed({3'b000, slen});
        end
        major <= smaj;
        wlen  <= slen;
        step  <= '0;
      end
      vrco_pkg::S_WALK_WR: begin
        if (step != wlen) begin
          step <= CW'(step + 1'b1);
          for (int a = 0; a < 3; a++) begin
            if (2'(a) == major) begin
              pcur[a] <= inc_neg[a] ? CW'(pcur[a] - 1'b1) : CW'(pcur[a] + 1'b1);
            end else if (err[a] > 0) begin
              pcur[a] <= inc_neg[a] ? CW'(pcur[a] - 1'b1) : CW'(pcur[a] + 1'b1);
              err[a]  <= err[a] - $signed({2'b00, wlen, 1'b0})
                                + $signed({2'b00, dlt[a], 1'b0});
            end else begin
              err[a]  <= err[a] + $signed({2'b00, dlt[a], 1'b0});
            end
          end
        end
      end
      vrco_pkg::S_RD_EVAL: begin
        res_occ <= rd_occ;
        res_vis <= rd_vis;
        if (rd_occ == '0 && 32'(rd_vis) <= 32'(free_limit)) begin
          res_cost <= vrco_pkg::FULL_COST;
        end
      end
      vrco_pkg::S_DIV: begin
        if (div_done) begin
          res_cost <= div_quot;
        end
      end
      vrco_pkg::S_RESP: begin
        if (out_free) begin
          status         <= res_status;
          cost           <= res_cost;
          occupied_count <= vrco_pkg::OUT_CNT_W'(32'(res_occ));
          visit_count    <= vrco_pkg::OUT_CNT_W'(32'(res_vis));
        end
      end
      default: ;
    endcase
  end

  vrco_grid_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (AW),
    .DATA_W (2 * CB)
  ) u_mem (
    .clk   (clk),
    .raddr (mem_addr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata)
  );

  vrco_cost_div #(
    .CNT_W (CB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (max_visits),
    .done  (div_done),
    .quot  (div_quot)
  );

  // The running maximum only ever falls during a clearing sweep.
  `VRC_ASSERT_NXT(a_max_keeps, clk, rst, state != vrco_pkg::S_CLR, max_visits >= $past(max_visits))
  // The walk never runs past the major axis length.
  `VRC_ASSERT_IMP(a_walk_bound, clk, rst, state == vrco_pkg::S_WALK_WR, step <= wlen)
  // A fresh result only comes out of the hand-off step.
  `VRC_ASSERT_IMP(a_out_src, clk, rst, $rose(out_valid), $past(state) == vrco_pkg::S_RESP)
  // The divider only reports while the sequencer waits on it.
  `VRC_ASSERT_IMP(a_div_wait, clk, rst, div_done, state == vrco_pkg::S_DIV)

endmodule

// File: tb/sv/voxel_ray_cast_occupancy_tb.sv
// ----------------------------------------------------------------------------
// Voxel ray cast occupancy testbench
// Drives clear, insert, read and unused commands through several register
// settings and checks every result against a cycle-free software copy of the
// grid, with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module voxel_ray_cast_occupancy_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GX = 64;
  localparam int GY = 64;
  localparam int GZ = 32;
  localparam int NCELL = GX * GY * GZ;
  localparam int CAM_X = GX / 2;
  localparam int CAM_Y = GY / 2;
  localparam int CNT_TOP = 65535;
  // Three full sweeps of the memory (reset plus two clears) and about 600
  // transactions, with stalls, taken several times.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    vrco_pkg::cmd_t     op;
    logic signed [15:0] px, py, pz;
    logic [5:0]        vx, vy;
    logic [4:0]        vz;
  } command_t;

  typedef struct {
    logic [1:0]  st;
    logic [7:0]  cst;
    logic [15:0] occ;
    logic [15:0] vis;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = vrco_pkg::CMD_NONE;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [5:0] voxel_x = '0, voxel_y = '0;
  logic [4:0] voxel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [7:0] cost;
  logic [15:0] occupied_count, visit_count;
  logic cfg_we = 1'b0;
  logic [vrco_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vrco_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  voxel_ray_cast_occupancy dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cost(cost),
    .occupied_count(occupied_count), .visit_count(visit_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Software copy of the grid and of the registers.
  logic [15:0] occ_grid [0:NCELL-1];
  logic [15:0] vis_grid [0:NCELL-1];
  logic [15:0] peak_visits;
  logic [15:0] inv_res;
  logic [31:0] range_sq_lim;
  logic [15:0] free_lim;
  logic [15:0] block_lim;
  logic        occ_only;

  command_t   pending_cmds[$];
  answer_t    expected_answers[$];
  int         failures = 0;
  bit         no_idle = 1'b1;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         last_tx = CAM_X, last_ty = CAM_Y, last_tz = 0;

  function automatic int cell_index(longint x, longint y, longint z);
    return int'((x * GY + y) * GZ + z);
  endfunction

  function automatic bit in_grid(longint x, longint y, longint z);
    return x >= 0 && x < GX && y >= 0 && y < GY && z >= 0 && z < GZ;
  endfunction

  function automatic void wipe_grid();
    for (int i = 0; i < NCELL; i++) begin
      occ_grid[i] = '0;
      vis_grid[i] = '0;
    end
    peak_visits = '0;
  endfunction

  function automatic void add_cmd(command_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic void bump_visit(longint x, longint y, longint z);
    int c;
    if (!in_grid(x, y, z)) return;
    c = cell_index(x, y, z);
    if (vis_grid[c] != CNT_TOP) vis_grid[c] = vis_grid[c] + 1;
    if (vis_grid[c] > peak_visits) peak_visits = vis_grid[c];
  endfunction

  // Voxel index with the whole sum truncated toward zero, so a slightly
  // negative coordinate lands on index zero rather than minus one.
  function automatic longint voxel_of(longint scaled, longint offset);
    longint t;
    t = scaled + offset * 65536;
    if (t >= 0) return t / 65536;
    return -((-t) / 65536);
  endfunction

  // 3D Bresenham walk from the camera voxel to the target, both ends visited.
  function automatic void trace_ray(longint tgt[3]);
    longint p[3], d[3], stp[3], acc[3];
    longint len;
    int major;
    p[0] = CAM_X; p[1] = CAM_Y; p[2] = 0;
    for (int a = 0; a < 3; a++) begin
      stp[a] = (tgt[a] < p[a]) ? -1 : 1;
      d[a] = (tgt[a] < p[a]) ? p[a] - tgt[a] : tgt[a] - p[a];
    end
    if (d[0] >= d[1] && d[0] >= d[2]) major = 0;
    else if (d[1] >= d[0] && d[1] >= d[2]) major = 1;
    else major = 2;
    len = d[major];
    for (int a = 0; a < 3; a++) acc[a] = 2 * d[a] - len;
    for (longint i = 0; i < len; i++) begin
      bump_visit(p[0], p[1], p[2]);
      for (int a = 0; a < 3; a++) begin
        if (a != major) begin
          if (acc[a] > 0) begin
            p[a] += stp[a];
            acc[a] -= 2 * len;
          end
          acc[a] += 2 * d[a];
        end
      end
      p[major] += stp[major];
    end
    bump_visit(p[0], p[1], p[2]);
  endfunction

  function automatic answer_t apply_command(command_t c);
    answer_t r;
    longint pos[3], tgt[3], off[3];
    longint unsigned sq;
    int cell_idx;
    r = '{st: vrco_pkg::ST_DONE, cst: 8'd0, occ: 16'd0, vis: 16'd0};
    case (c.op)
      vrco_pkg::CMD_CLEAR: wipe_grid();
      vrco_pkg::CMD_INSERT: begin
        pos[0] = c.px; pos[1] = c.py; pos[2] = c.pz;
        off[0] = CAM_X; off[1] = CAM_Y; off[2] = 0;
        sq = 0;
        for (int a = 0; a < 3; a++) sq += longint'(pos[a] * pos[a]);
        if (sq > range_sq_lim) begin
          r.st = vrco_pkg::ST_RANGE;
        end else begin
          for (int a = 0; a < 3; a++) tgt[a] = voxel_of(pos[a] * longint'(inv_res), off[a]);
          if (!in_grid(tgt[0], tgt[1], tgt[2])) begin
            r.st = vrco_pkg::ST_OUTSIDE;
          end else begin
            cell_idx = cell_index(tgt[0], tgt[1], tgt[2]);
            if (occ_grid[cell_idx] != CNT_TOP) occ_grid[cell_idx] = occ_grid[cell_idx] + 1;
            if (!occ_only) trace_ray(tgt);
          end
        end
      end
      vrco_pkg::CMD_READ: begin
        if (!in_grid(c.vx, c.vy, c.vz)) begin
          r.st = vrco_pkg::ST_OUTSIDE;
        end else begin
          cell_idx = cell_index(c.vx, c.vy, c.vz);
          r.occ = occ_grid[cell_idx];
          r.vis = vis_grid[cell_idx];
          if (r.occ != 0) r.cst = 8'd0;
          else if (r.vis <= free_lim) r.cst = vrco_pkg::FULL_COST;
          else if (r.vis > block_lim) r.cst = 8'd0;
          else if (r.vis >= peak_visits) r.cst = 8'd0;
          else r.cst = 8'((longint'(peak_visits - r.vis) * 255) / longint'(peak_visits));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender: one transaction waits on the port until it is taken. The next one
  // follows right away or, unless idling is off, after a random run of idle cycles.
  always @(posedge clk) begin
    command_t nxt;
    answer_t fresh;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fresh = apply_command('{op: vrco_pkg::cmd_t'(cmd), px: pos_x, py: pos_y,
            pz: pos_z, vx: voxel_x, vy: voxel_y, vz: voxel_z});
        expected_answers = {expected_answers, fresh};
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 20)) begin
          nxt = pending_cmds.pop_front();
          in_valid <= 1'b1;
          cmd <= nxt.op;
          pos_x <= nxt.px;
          pos_y <= nxt.py;
          pos_z <= nxt.pz;
          voxel_x <= nxt.vx;
          voxel_y <= nxt.vy;
          voxel_z <= nxt.vz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so that the
  // output register fills, the sequencer blocks and in_ready drops.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 20);
    end
  end

  // Checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("result with no transaction outstanding: status %0d", status);
        failures++;
      end else begin
        e = expected_answers.pop_front();
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          failures++;
        end
        if (cost !== e.cst) begin
          $error("cost expected %0d actual %0d", e.cst, cost);
          failures++;
        end
        if (occupied_count !== e.occ) begin
          $error("occupied_count expected %0d actual %0d", e.occ, occupied_count);
          failures++;
        end
        if (visit_count !== e.vis) begin
          $error("visit_count expected %0d actual %0d", e.vis, visit_count);
          failures++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic command_t read_cmd(int x, int y, int z);
    return '{op: vrco_pkg::CMD_READ, px: 16'sd0, py: 16'sd0, pz: 16'sd0,
             vx: 6'(x), vy: 6'(y), vz: 5'(z)};
  endfunction

  function automatic command_t insert_cmd(longint x, longint y, longint z);
    return '{op: vrco_pkg::CMD_INSERT, px: 16'(x), py: 16'(y), pz: 16'(z),
             vx: 6'($urandom), vy: 6'($urandom), vz: 5'($urandom)};
  endfunction

  // Position that lands near voxel v on one axis under the current scale.
  function automatic longint aim_at(int v, int cam);
    longint p;
    p = ((longint'(v) - cam) * 65536 + longint'($urandom_range(65535)) - 32768)
        / longint'(inv_res);
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p;
  endfunction

  function automatic command_t random_cmd();
    int pick, k;
    pick = $urandom_range(99);
    if (pick < 2) begin
      return '{op: vrco_pkg::CMD_NONE, px: 16'($urandom), py: 16'($urandom),
               pz: 16'($urandom), vx: 6'($urandom), vy: 6'($urandom), vz: 5'($urandom)};
    end else if (pick < 20) begin
      return read_cmd($urandom_range(GX - 1), $urandom_range(GY - 1), $urandom_range(GZ - 1));
    end else if (pick < 40) begin
      // Somewhere on the most recent ray, where visits without hits gather.
      k = $urandom_range(8);
      return read_cmd(CAM_X + (last_tx - CAM_X) * k / 8, CAM_Y + (last_ty - CAM_Y) * k / 8,
                      last_tz * k / 8);
    end else if (pick < 50) begin
      return insert_cmd(longint'($signed(16'($urandom))), longint'($signed(16'($urandom))),
                        longint'($signed(16'($urandom))));
    end else begin
      // Short rays are cheap; most targets stay near the camera.
      if ($urandom_range(3) == 0) begin
        last_tx = $urandom_range(GX - 1);
        last_ty = $urandom_range(GY - 1);
        last_tz = $urandom_range(GZ - 1);
      end else begin
        last_tx = CAM_X - 8 + $urandom_range(16);
        last_ty = CAM_Y - 8 + $urandom_range(16);
        last_tz = $urandom_range(8);
      end
      return insert_cmd(aim_at(last_tx, CAM_X), aim_at(last_ty, CAM_Y), aim_at(last_tz, 0));
    end
  endfunction

  task automatic write_reg(vrco_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      vrco_pkg::REG_INV_RES:  inv_res = val[15:0];
      vrco_pkg::REG_RANGE_SQ: range_sq_lim = val;
      vrco_pkg::REG_FREE_LIM: free_lim = val[15:0];
      vrco_pkg::REG_OCC_LIM:  block_lim = val[15:0];
      vrco_pkg::REG_OCC_ONLY: occ_only = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender pause: nothing queued, nothing on the port, nothing outstanding.
  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_valid && expected_answers.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) add_cmd(random_cmd());
  endtask

  task automatic set_regs(logic [15:0] ir, logic [31:0] rq, logic [15:0] fl,
                          logic [15:0] bl, logic oo);
    write_reg(vrco_pkg::REG_INV_RES, ir);
    write_reg(vrco_pkg::REG_RANGE_SQ, rq);
    write_reg(vrco_pkg::REG_FREE_LIM, fl);
    write_reg(vrco_pkg::REG_OCC_LIM, bl);
    write_reg(vrco_pkg::REG_OCC_ONLY, oo);
  endtask

  initial begin
    inv_res = 16'd2560;
    range_sq_lim = 32'd3221225472;
    free_lim = 16'd0;
    block_lim = 16'd65535;
    occ_only = 1'b0;
    wipe_grid();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset values, no idling on either side.
    add_cmd(read_cmd(CAM_X, CAM_Y, 0));
    add_cmd(insert_cmd(0, 0, 0));
    add_cmd(insert_cmd(300, -200, 400));
    add_cmd(insert_cmd(-1, -1, -1));       // z to index 0, x and y to cam - 1
    add_cmd(insert_cmd(-820, -820, 0));    // corner of the grid
    add_cmd(insert_cmd(806, 806, 806));    // far corner
    add_cmd(insert_cmd(32767, 32767, 32767));
    add_cmd(insert_cmd(-32768, -32768, -32768));
    add_cmd(insert_cmd(0, 0, -30));        // below the grid floor
    add_cmd(read_cmd(CAM_X, CAM_Y, 0));
    add_cmd(read_cmd(CAM_X + 5, CAM_Y - 3, 7));
    add_cmd(read_cmd(CAM_X + 10, CAM_Y - 7, 10));
    add_cmd(read_cmd(0, 0, 0));
    add_cmd(read_cmd(63, 63, 31));
    add_cmd('{op: vrco_pkg::CMD_NONE, px: 16'sh7fff, py: -16'sd1, pz: 16'sh1234,
              vx: 6'd63, vy: 6'd0, vz: 5'd31});
    add_cmd('{op: vrco_pkg::CMD_CLEAR, px: 16'sd0, py: 16'sd0, pz: 16'sd0,
              vx: 6'd0, vy: 6'd0, vz: 5'd0});
    add_cmd(read_cmd(CAM_X, CAM_Y, 0));
    add_cmd(insert_cmd(100, 50, 20));
    add_cmd(read_cmd(CAM_X + 3, CAM_Y + 1, 0));
    drain();

    // One voxel per meter, a tight range and a narrow free band.
    set_regs(16'd256, 32'd5000000, 16'd1, 16'd1000, 1'b0);
    no_idle = 1'b0;
    queue_random(60);
    hold_req = 1'b1;
    queue_random(90);
    drain();

    // Finest scale, only the hit voxel counted.
    set_regs(16'd65535, 32'd3221225472, 16'd65535, 16'd65535, 1'b1);
    queue_random(100);
    drain();

    // Coarsest scale and a zero range, so only the origin survives.
    set_regs(16'd1, 32'd0, 16'd0, 16'd0, 1'b0);
    queue_random(40);
    add_cmd(insert_cmd(0, 0, 0));
    drain();

    // Back to a normal scale after a clear; the first stretch runs without idling.
    set_regs(16'd2560, 32'd100000000, 16'd0, 16'd65535, 1'b0);
    add_cmd('{op: vrco_pkg::CMD_CLEAR, px: 16'sd0, py: 16'sd0, pz: 16'sd0,
              vx: 6'd0, vy: 6'd0, vz: 5'd0});
    drain();
    no_idle = 1'b1;
    queue_random(80);
    drain();
    no_idle = 1'b0;
    write_reg(vrco_pkg::REG_OCC_LIM, 16'd3);
    write_reg(vrco_pkg::REG_FREE_LIM, 16'd0);
    queue_random(180);
    drain();

    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/vrco_pkg.sv
design/vrco_grid_mem.sv
design/vrco_cost_div.sv
design/voxel_ray_cast_occupancy.sv
tb/sv/voxel_ray_cast_occupancy_tb.sv
